/* rtl/lhcr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the least-hits cache replacement unit.
// Depends on nothing; every other file imports it.
package lhcr_pkg;

    localparam int ENTRIES    = 4;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W       = 16;
    localparam int CNT_W      = 15;
    localparam int SLOT_W     = 4;
    localparam int OUTCOME_W  = 2;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUTCOME_W - SLOT_W - ID_W;

    localparam logic [ID_W-1:0]  EMPTY_MARK = 16'hFFFF;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 15'h7FFF;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ENTRIES - 1);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_ERROR = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* rtl/lhcr_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the least-hits cache replacement unit.
// Depends on lhcr_pkg; drives commands into lhcr_datapath.
module lhcr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lhcr_pkg::dp_status_t status,
    output lhcr_pkg::dp_cmd_t    cmd
);
    import lhcr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = !status.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/lhcr_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the least-hits cache replacement unit: tag and hit-count store,
// the one-slot-per-cycle scan, the commit logic and the output register.
// Depends on lhcr_pkg; commanded by lhcr_ctrl.
module lhcr_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lhcr_pkg::dp_cmd_t            cmd,
    output lhcr_pkg::dp_status_t         status,
    input  logic [lhcr_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lhcr_pkg::OUT_TDATA_W-1:0] out_data
);
    import lhcr_pkg::*;

    logic [ID_W-1:0]  tags_reg   [ENTRIES];
    logic [CNT_W-1:0] counts_reg [ENTRIES];

    logic [ID_W-1:0]  req_reg;
    logic [ID_W-1:0]  pa_reg;
    logic [ID_W-1:0]  pb_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             vic_found_reg;
    logic [IDX_W-1:0] vic_idx_reg;
    logic [ID_W-1:0]  vic_tag_reg;
    logic [CNT_W-1:0] least_reg;

    logic             out_valid_reg;
    outcome_t         outcome_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ID_W-1:0]  evicted_reg;

    logic [ID_W-1:0]  cur_tag;
    logic [CNT_W-1:0] cur_cnt;
    logic             cur_match;
    logic             cur_free;
    logic             cur_cand;

    // Commit decision.
    outcome_t         outcome_next;
    logic [IDX_W-1:0] slot_next;
    logic [ID_W-1:0]  evicted_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [ID_W-1:0]  wr_tag;
    logic [CNT_W-1:0] wr_cnt;

    assign cur_tag   = tags_reg[idx_reg];
    assign cur_cnt   = counts_reg[idx_reg];
    assign cur_match = (cur_tag == req_reg);
    assign cur_free  = (cur_tag == EMPTY_MARK);
    assign cur_cand  = (cur_tag != pa_reg) && (cur_tag != pb_reg) && (cur_cnt < least_reg);

    assign status.scan_last = (idx_reg == LAST_IDX);
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        outcome_next = OUT_ERROR;
        slot_next    = '0;
        evicted_next = EMPTY_MARK;
        wr_en        = 1'b0;
        wr_idx       = '0;
        wr_tag       = req_reg;
        wr_cnt       = '0;
        priority if (req_reg == EMPTY_MARK)
        begin
            outcome_next = OUT_ERROR;
        end
        else if (hit_found_reg)
        begin
            outcome_next = OUT_HIT;
            slot_next    = hit_idx_reg;
            wr_en        = 1'b1;
            wr_idx       = hit_idx_reg;
            wr_tag       = req_reg;
            wr_cnt       = (hit_cnt_reg == COUNT_MAX) ? COUNT_MAX : hit_cnt_reg + 1'b1;
        end
        else if (free_found_reg)
        begin
            outcome_next = OUT_FILL;
            slot_next    = free_idx_reg;
            wr_en        = 1'b1;
            wr_idx       = free_idx_reg;
        end
        else if (vic_found_reg)
        begin
            outcome_next = OUT_EVICT;
            slot_next    = vic_idx_reg;
            evicted_next = vic_tag_reg;
            wr_en        = 1'b1;
            wr_idx       = vic_idx_reg;
        end
        else
        begin
            outcome_next = OUT_ERROR;
        end
    end

    // Tag store: cleared to empty by reset, written only at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tags_reg[i]   <= EMPTY_MARK;
                counts_reg[i] <= '0;
            end
        end
        else if (cmd.commit && wr_en)
        begin
            tags_reg[wr_idx]   <= wr_tag;
            counts_reg[wr_idx] <= wr_cnt;
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            least_reg      <= COUNT_MAX;
        end
        else if (cmd.load)
        begin
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            least_reg      <= COUNT_MAX;
        end
        else if (cmd.scan)
        begin
            if (!status.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cur_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (cur_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (cur_cand)
            begin
                vic_found_reg <= 1'b1;
                least_reg     <= cur_cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data[ID_W-1:0];
            pa_reg  <= in_data[2*ID_W-1:ID_W];
            pb_reg  <= in_data[3*ID_W-1:2*ID_W];
        end
        if (cmd.scan)
        begin
            if (cur_match && !hit_found_reg)
            begin
                hit_idx_reg <= idx_reg;
                hit_cnt_reg <= cur_cnt;
            end
            if (cur_free && !free_found_reg)
            begin
                free_idx_reg <= idx_reg;
            end
            if (cur_cand)
            begin
                vic_idx_reg <= idx_reg;
                vic_tag_reg <= cur_tag;
            end
        end
    end

    // Output register: holds one result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            outcome_reg <= outcome_next;
            slot_reg    <= SLOT_W'(slot_next);
            evicted_reg <= evicted_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, evicted_reg, slot_reg, outcome_reg};

    // A commit never overwrites a result the sink has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("commit while output register still full");

    // Every commit presents a result on the next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not load the output register");

    // A recorded victim always has an unsaturated count.
    a_victim_count: assert property (@(posedge clk) disable iff (!rst_n)
        vic_found_reg |-> (least_reg != COUNT_MAX))
        else $error("victim recorded with a saturated count");

    // The scan index never leaves the store.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("scan index out of range");

endmodule

/* rtl/least_hits_cache_replacement_unit.sv */
`timescale 1ns / 1ps
// Least-hits cache replacement unit, top level. Each request is accepted, scanned
// reading one slot per cycle, and committed; no new request is taken until the commit
// is done, and an untaken result holds the next commit back.
// Reset (rst_n low, asynchronous): all slots empty, all hit counts zero, no result.
// Depends on lhcr_pkg, lhcr_ctrl and lhcr_datapath.
module least_hits_cache_replacement_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: request_id[15:0], protected_a[31:16], protected_b[47:32].
    input  logic [lhcr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: outcome[1:0], slot[5:2], evicted_id[21:6], zeros[23:22].
    output logic [lhcr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import lhcr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences each item through capture, a scan over every
    // slot, and a commit that updates the store and loads the result register.
    // A new item is taken as soon as the commit is done, even while its
    // result still waits in the output register.
    lhcr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath looks for a matching tag, the first empty slot and the
    // unprotected slot with the fewest hits in one pass, lowest index winning
    // ties, then applies hit, fill, eviction or error at commit.
    lhcr_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
